@@ design/ihte_pkg.sv @@
// constants and field widths for the ip header tuple extractor
package ihte_pkg;

    localparam int unsigned CNT_W  = 7;
    localparam int unsigned HLEN_W = 6;

    localparam logic [CNT_W-1:0]  COUNT_MAX    = 7'd127;
    localparam logic [HLEN_W-1:0] HLEN_MIN     = 6'd20;
    localparam logic [CNT_W-1:0]  V6_PORT_BASE = 7'd40;

    localparam logic [3:0] VER_IPV4 = 4'd4;
    localparam logic [3:0] VER_IPV6 = 4'd6;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [CNT_W-1:0] TCP_HDR_LEN = 7'd20;
    localparam logic [CNT_W-1:0] UDP_HDR_LEN = 7'd8;

    localparam logic [CNT_W-1:0] V4_MIN_LEN   = 7'd20;
    localparam logic [CNT_W-1:0] V6_MIN_LEN   = 7'd40;
    localparam logic [CNT_W-1:0] V4_PROTO_OFS = 7'd9;
    localparam logic [CNT_W-1:0] V4_SRC_OFS   = 7'd12;
    localparam logic [CNT_W-1:0] V4_DST_OFS   = 7'd16;
    localparam logic [CNT_W-1:0] V6_PROTO_OFS = 7'd6;
    localparam logic [CNT_W-1:0] V6_SRC_OFS   = 7'd8;
    localparam logic [CNT_W-1:0] V6_DST_OFS   = 7'd24;

    localparam int unsigned V4_ADDR_BYTES = 4;
    localparam int unsigned V6_ADDR_BYTES = 16;
    localparam int unsigned PORT_BYTES    = 4;

    localparam logic [1:0] FAM_NONE = 2'd0;
    localparam logic [1:0] FAM_IPV4 = 2'd1;
    localparam logic [1:0] FAM_IPV6 = 2'd2;

    localparam int unsigned OUT_DATA_W = 296;
    localparam int unsigned OUT_USER_W = 2;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [63:0] dst_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] src_addr_hi;
        logic [15:0] dst_port;
        logic [15:0] src_l4_port;
        logic [7:0]  protocol;
    } t_tuple;

endpackage

@@ design/ip_header_tuple_extractor_core.sv @@
// ip header tuple extractor: byte-serial ipv4/ipv6 five-tuple parser
// one input word accepted per cycle when the output register is free or drained
// a packet's tuple appears on the master side in the cycle after its last byte
// sustained throughput: one byte per cycle, bounded only by the output handshake
// synchronous active-low reset clears the parse state and the output valid flag
module ip_header_tuple_extractor_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // data_byte
    input  logic                               s_axis_tlast,  // last_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // protocol, src_l4_port, dst_port, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo
    output logic [ihte_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [ihte_pkg::OUT_USER_W-1:0]    m_axis_tuser   // family
);
    import ihte_pkg::*;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [3:0]        r_ver, n_ver;
    logic [HLEN_W-1:0] r_hlen, n_hlen;
    t_byte             r_proto, n_proto;
    t_byte             r_src [V6_ADDR_BYTES];
    t_byte             n_src [V6_ADDR_BYTES];
    t_byte             r_dst [V6_ADDR_BYTES];
    t_byte             n_dst [V6_ADDR_BYTES];
    t_byte             r_port [PORT_BYTES];
    t_byte             n_port [PORT_BYTES];

    logic              r_out_valid;
    t_tuple            r_out_tuple, n_out_tuple;
    logic [1:0]        r_out_family, n_out_family;

    logic              accept;
    logic              is_v4, is_v6;
    logic [CNT_W-1:0]  port_base;
    logic [1:0]        port_ofs;
    logic              in_port_win;
    logic [HLEN_W-1:0] ihl_bytes;
    logic [CNT_W-1:0]  res_base;
    logic [CNT_W-1:0]  res_need;
    logic              res_ports;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // next parse state for the byte at position r_count
    always_comb begin
        n_count = (r_count != COUNT_MAX) ? r_count + 7'd1 : r_count;
        n_ver   = r_ver;
        n_hlen  = r_hlen;
        n_proto = r_proto;
        for (int j = 0; j < V6_ADDR_BYTES; j++) begin
            n_src[j] = r_src[j];
            n_dst[j] = r_dst[j];
        end
        for (int j = 0; j < PORT_BYTES; j++) begin
            n_port[j] = r_port[j];
        end

        is_v4       = (r_ver == VER_IPV4);
        is_v6       = (r_ver == VER_IPV6);
        port_base   = is_v6 ? V6_PORT_BASE : {1'b0, r_hlen};
        port_ofs    = 2'(r_count - port_base);
        in_port_win = (r_count >= port_base) && (r_count < port_base + 7'd4);
        ihl_bytes   = {s_axis_tdata[3:0], 2'b00};

        if (r_count == '0) begin
            n_ver  = s_axis_tdata[7:4];
            n_hlen = (ihl_bytes < HLEN_MIN) ? HLEN_MIN : ihl_bytes;
        end else if (r_count != COUNT_MAX) begin
            if (is_v4) begin
                if (r_count == V4_PROTO_OFS) begin
                    n_proto = s_axis_tdata;
                end
                for (int j = 0; j < V4_ADDR_BYTES; j++) begin
                    if (r_count == V4_SRC_OFS + CNT_W'(j)) begin
                        n_src[j] = s_axis_tdata;
                    end
                    if (r_count == V4_DST_OFS + CNT_W'(j)) begin
                        n_dst[j] = s_axis_tdata;
                    end
                end
            end else if (is_v6) begin
                if (r_count == V6_PROTO_OFS) begin
                    n_proto = s_axis_tdata;
                end
                for (int j = 0; j < V6_ADDR_BYTES; j++) begin
                    if (r_count == V6_SRC_OFS + CNT_W'(j)) begin
                        n_src[j] = s_axis_tdata;
                    end
                    if (r_count == V6_DST_OFS + CNT_W'(j)) begin
                        n_dst[j] = s_axis_tdata;
                    end
                end
            end
            for (int j = 0; j < PORT_BYTES; j++) begin
                if (in_port_win && (port_ofs == 2'(j))) begin
                    n_port[j] = s_axis_tdata;
                end
            end
        end
    end

    // tuple built from the state that includes the current byte
    always_comb begin
        n_out_family = FAM_NONE;
        res_base     = '0;
        if ((n_ver == VER_IPV4) && (n_count >= V4_MIN_LEN)) begin
            n_out_family = FAM_IPV4;
            res_base     = {1'b0, n_hlen};
        end else if ((n_ver == VER_IPV6) && (n_count >= V6_MIN_LEN)) begin
            n_out_family = FAM_IPV6;
            res_base     = V6_PORT_BASE;
        end

        res_need  = '0;
        res_ports = 1'b0;
        if (n_proto == PROTO_TCP) begin
            res_need  = res_base + TCP_HDR_LEN;
            res_ports = 1'b1;
        end else if (n_proto == PROTO_UDP) begin
            res_need  = res_base + UDP_HDR_LEN;
            res_ports = 1'b1;
        end
        if (n_count < res_need) begin
            n_out_family = FAM_NONE;
        end

        n_out_tuple = '0;
        if (n_out_family != FAM_NONE) begin
            n_out_tuple.protocol = n_proto;
            if (res_ports) begin
                n_out_tuple.src_l4_port = {n_port[0], n_port[1]};
                n_out_tuple.dst_port    = {n_port[2], n_port[3]};
            end
            for (int j = 0; j < 8; j++) begin
                n_out_tuple.src_addr_hi[63-8*j -: 8] = n_src[j];
                n_out_tuple.dst_addr_hi[63-8*j -: 8] = n_dst[j];
                if (n_out_family == FAM_IPV6) begin
                    n_out_tuple.src_addr_lo[63-8*j -: 8] = n_src[j+8];
                    n_out_tuple.dst_addr_lo[63-8*j -: 8] = n_dst[j+8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ver   <= '0;
            r_hlen  <= HLEN_MIN;
            r_proto <= '0;
            for (int j = 0; j < V6_ADDR_BYTES; j++) begin
                r_src[j] <= '0;
                r_dst[j] <= '0;
            end
            for (int j = 0; j < PORT_BYTES; j++) begin
                r_port[j] <= '0;
            end
        end else if (accept) begin
            if (s_axis_tlast) begin
                // end of packet: back to the idle parse state
                r_count <= '0;
                r_ver   <= '0;
                r_hlen  <= HLEN_MIN;
                r_proto <= '0;
                for (int j = 0; j < V6_ADDR_BYTES; j++) begin
                    r_src[j] <= '0;
                    r_dst[j] <= '0;
                end
                for (int j = 0; j < PORT_BYTES; j++) begin
                    r_port[j] <= '0;
                end
            end else begin
                r_count <= n_count;
                r_ver   <= n_ver;
                r_hlen  <= n_hlen;
                r_proto <= n_proto;
                for (int j = 0; j < V6_ADDR_BYTES; j++) begin
                    r_src[j] <= n_src[j];
                    r_dst[j] <= n_dst[j];
                end
                for (int j = 0; j < PORT_BYTES; j++) begin
                    r_port[j] <= n_port[j];
                end
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && s_axis_tlast) begin
            r_out_tuple  <= n_out_tuple;
            r_out_family <= n_out_family;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tuple;
    assign m_axis_tuser  = r_out_family;

endmodule

@@ bench/tb_ip_header_tuple_extractor_core.sv @@
// self-checking testbench for the ip header tuple extractor core
module tb_ip_header_tuple_extractor_core;
    import ihte_pkg::*;

    localparam int unsigned CLK_HALF    = 10;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PRINT_MAX   = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_pkt_byte;

    typedef struct packed {
        logic [1:0] family;
        t_tuple     tuple;
    } t_tuple_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'h00;   // data_byte
    logic                  s_axis_tlast = 1'b0;    // last_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // protocol, src_l4_port, dst_port, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;           // family

    t_pkt_byte     tx_bytes[$];
    t_tuple_result tuple_expect_q[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_ack = 0;
    int unsigned hold_left = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    logic        in_fire = 1'b0;

    // parser state of the predictor
    logic [6:0]  byte_cnt;
    logic [3:0]  ver_nib;
    logic [5:0]  hdr_len;
    logic [7:0]  proto_byte;
    logic [63:0] src_words[2];
    logic [63:0] dst_words[2];
    logic [15:0] port_vals[2];

    ip_header_tuple_extractor_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic logic [63:0] with_byte(logic [63:0] w, int unsigned pos, logic [7:0] b);
        logic [63:0] r;
        r = w;
        r[8 * (7 - (pos % 8)) +: 8] = b;
        return r;
    endfunction

    task automatic clear_parser();
        byte_cnt   = '0;
        ver_nib    = '0;
        hdr_len    = HLEN_MIN;
        proto_byte = '0;
        src_words  = '{64'd0, 64'd0};
        dst_words  = '{64'd0, 64'd0};
        port_vals  = '{16'd0, 16'd0};
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic lst);
        int unsigned   idx;
        int unsigned   base;
        int unsigned   need;
        int unsigned   total;
        int unsigned   k;
        logic [1:0]    fam;
        logic          has_ports;
        t_tuple_result r;
        idx = 32'(byte_cnt);
        if (idx == 0) begin
            ver_nib = b[7:4];
            hdr_len = (b[3:0] < 4'd5) ? HLEN_MIN : {b[3:0], 2'b00};
        end else if (idx < 32'(COUNT_MAX)) begin
            base = (ver_nib == VER_IPV6) ? 32'(V6_PORT_BASE) : 32'(hdr_len);
            if (ver_nib == VER_IPV4) begin
                if (idx == 32'(V4_PROTO_OFS)) begin
                    proto_byte = b;
                end else if (idx >= 32'(V4_SRC_OFS) &&
                             idx < 32'(V4_SRC_OFS) + V4_ADDR_BYTES) begin
                    src_words[0] = with_byte(src_words[0], idx - 32'(V4_SRC_OFS), b);
                end else if (idx >= 32'(V4_DST_OFS) &&
                             idx < 32'(V4_DST_OFS) + V4_ADDR_BYTES) begin
                    dst_words[0] = with_byte(dst_words[0], idx - 32'(V4_DST_OFS), b);
                end
            end else if (ver_nib == VER_IPV6) begin
                if (idx == 32'(V6_PROTO_OFS)) begin
                    proto_byte = b;
                end else if (idx >= 32'(V6_SRC_OFS) &&
                             idx < 32'(V6_SRC_OFS) + V6_ADDR_BYTES) begin
                    k = idx - 32'(V6_SRC_OFS);
                    src_words[k[3]] = with_byte(src_words[k[3]], k, b);
                end else if (idx >= 32'(V6_DST_OFS) &&
                             idx < 32'(V6_DST_OFS) + V6_ADDR_BYTES) begin
                    k = idx - 32'(V6_DST_OFS);
                    dst_words[k[3]] = with_byte(dst_words[k[3]], k, b);
                end
            end
            if (idx >= base && idx < base + PORT_BYTES) begin
                k = idx - base;
                if (k[0]) begin
                    port_vals[k[1]][7:0] = b;
                end else begin
                    port_vals[k[1]][15:8] = b;
                end
            end
        end
        if (byte_cnt < COUNT_MAX) begin
            byte_cnt = byte_cnt + 7'd1;
        end
        if (lst) begin
            total = 32'(byte_cnt);
            fam   = FAM_NONE;
            base  = 0;
            if (ver_nib == VER_IPV4 && total >= 32'(V4_MIN_LEN)) begin
                base = 32'(hdr_len);
                fam  = FAM_IPV4;
            end else if (ver_nib == VER_IPV6 && total >= 32'(V6_MIN_LEN)) begin
                base = 32'(V6_PORT_BASE);
                fam  = FAM_IPV6;
            end
            has_ports = (proto_byte == PROTO_TCP) || (proto_byte == PROTO_UDP);
            need = 0;
            if (proto_byte == PROTO_TCP) begin
                need = base + 32'(TCP_HDR_LEN);
            end else if (proto_byte == PROTO_UDP) begin
                need = base + 32'(UDP_HDR_LEN);
            end
            if (total < need) begin
                fam = FAM_NONE;
            end
            r = '0;
            if (fam != FAM_NONE) begin
                r.family            = fam;
                r.tuple.protocol    = proto_byte;
                r.tuple.src_l4_port = has_ports ? port_vals[0] : 16'd0;
                r.tuple.dst_port    = has_ports ? port_vals[1] : 16'd0;
                r.tuple.src_addr_hi = src_words[0];
                r.tuple.src_addr_lo = (fam == FAM_IPV6) ? src_words[1] : 64'd0;
                r.tuple.dst_addr_hi = dst_words[0];
                r.tuple.dst_addr_lo = (fam == FAM_IPV6) ? dst_words[1] : 64'd0;
            end
            tuple_expect_q.push_back(r);
            clear_parser();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_MAX) begin
            $display("mismatch %s: got %h expected %h", what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        t_pkt_byte w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                w = tx_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= w.data;
                s_axis_tlast  <= w.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_tuple_result want;
        t_tuple        got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (tuple_expect_q.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata[63:0], 64'd0);
                end else begin
                    want = tuple_expect_q.pop_front();
                    got  = m_axis_tdata;
                    check_field("family", 64'(m_axis_tuser), 64'(want.family));
                    check_field("protocol", 64'(got.protocol), 64'(want.tuple.protocol));
                    check_field("src_l4_port", 64'(got.src_l4_port),
                                64'(want.tuple.src_l4_port));
                    check_field("dst_port", 64'(got.dst_port), 64'(want.tuple.dst_port));
                    check_field("src_addr_hi", got.src_addr_hi, want.tuple.src_addr_hi);
                    check_field("src_addr_lo", got.src_addr_lo, want.tuple.src_addr_lo);
                    check_field("dst_addr_hi", got.dst_addr_hi, want.tuple.dst_addr_hi);
                    check_field("dst_addr_lo", got.dst_addr_lo, want.tuple.dst_addr_lo);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata, s_axis_tlast);
            end
        end
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL ip_header_tuple_extractor_core");
            $finish;
        end
    end

    // fill < 0 gives random content
    task automatic add_packet(input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [7:0] proto, input int unsigned len,
                              input int fill);
        t_pkt_byte w;
        for (int unsigned i = 0; i < len; i++) begin
            w.data = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (i == 0) begin
                w.data = {ver, ihl};
            end else if (ver == VER_IPV4 && i == 32'(V4_PROTO_OFS)) begin
                w.data = proto;
            end else if (ver == VER_IPV6 && i == 32'(V6_PROTO_OFS)) begin
                w.data = proto;
            end
            w.last = (i == len - 1);
            tx_bytes.push_back(w);
        end
    endtask

    task automatic add_random_packet();
        int unsigned pick;
        int unsigned hl;
        int unsigned need;
        int unsigned len;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            add_packet(4'($urandom), 4'($urandom), 8'($urandom), $urandom_range(1, 60), -1);
        end else begin
            ver = ($urandom_range(0, 2) == 0) ? VER_IPV6 : VER_IPV4;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                proto = PROTO_TCP;
            end else if (pick < 80) begin
                proto = PROTO_UDP;
            end else begin
                proto = 8'($urandom);
            end
            if (ver == VER_IPV4 && $urandom_range(0, 9) != 0) begin
                ihl = 4'($urandom_range(5, 15));
            end else begin
                ihl = 4'($urandom_range(0, 15));
            end
            hl = (ihl < 4'd5) ? 32'(HLEN_MIN) : 32'(ihl) * 4;
            need = (ver == VER_IPV6) ? 32'(V6_PORT_BASE) : hl;
            if (proto == PROTO_TCP) begin
                need = need + 32'(TCP_HDR_LEN);
            end else if (proto == PROTO_UDP) begin
                need = need + 32'(UDP_HDR_LEN);
            end
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                len = need + $urandom_range(0, 6);
            end else if (pick < 95) begin
                len = $urandom_range(1, need);
            end else begin
                len = $urandom_range(need, 140);
            end
            add_packet(ver, ihl, proto, len, -1);
        end
    endtask

    task automatic wait_drained();
        while (tx_bytes.size() != 0 || s_axis_tvalid || tuple_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (3) add_random_packet();
        wait_drained();
    endtask

    initial begin
        clear_parser();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed packets
        add_packet(VER_IPV4, 4'd5, PROTO_TCP, 40, -1);
        add_packet(VER_IPV4, 4'd5, PROTO_UDP, 28, -1);
        add_packet(VER_IPV4, 4'd15, PROTO_TCP, 80, -1);
        add_packet(VER_IPV4, 4'd5, PROTO_TCP, 39, -1);
        add_packet(VER_IPV4, 4'd0, PROTO_UDP, 28, -1);
        add_packet(VER_IPV4, 4'd5, 8'd1, 20, -1);
        add_packet(VER_IPV4, 4'd5, 8'd1, 19, -1);
        add_packet(VER_IPV4, 4'd5, PROTO_TCP, 1, -1);
        add_packet(VER_IPV6, 4'd0, PROTO_TCP, 60, -1);
        add_packet(VER_IPV6, 4'd9, PROTO_UDP, 48, -1);
        add_packet(VER_IPV6, 4'd0, 8'd58, 40, -1);
        add_packet(VER_IPV6, 4'd0, PROTO_UDP, 39, -1);
        add_packet(4'd5, 4'd5, PROTO_TCP, 40, -1);
        add_packet(VER_IPV6, 4'd0, PROTO_TCP, 140, -1);
        add_packet(4'd15, 4'd15, 8'hFF, 24, 255);
        add_packet(4'd0, 4'd0, 8'h00, 24, 0);
        wait_drained();

        run_random_phase(0, 0);
        run_random_phase(53, 0);
        run_random_phase(0, 53);
        run_random_phase(25, 25);

        // long receiver hold while the sender keeps going
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = hold_req + 1;
        repeat (6) add_packet(4'($urandom), 4'($urandom), 8'($urandom),
                              $urandom_range(1, 4), -1);
        repeat (6) add_random_packet();
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS ip_header_tuple_extractor_core");
        end else begin
            $display("FAIL ip_header_tuple_extractor_core");
        end
        $finish;
    end

endmodule
